### hw/rtl/nrhf_pkg.sv
// Shared types and constants for the NDEF record header framer.
// Holds the job descriptor passed from the checker front to the byte emitter.
// No dependencies.
package nrhf_pkg;

   localparam int COUNT_WIDTH = 16;
   localparam int USED_WIDTH  = 16;
   localparam int LEN_WIDTH   = 32;
   localparam int SUM_WIDTH   = LEN_WIDTH + 2;
   localparam int SMALL_WIDTH = 10;
   localparam int MAX_BYTES   = 7;
   localparam int IDX_WIDTH   = $clog2(MAX_BYTES);
   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_WIDTH   = $clog2(QUEUE_DEPTH);
   localparam int FILL_WIDTH  = $clog2(QUEUE_DEPTH + 1);

   localparam logic [SUM_WIDTH-1:0] COUNT_MAX =
      SUM_WIDTH'((64'd1 << COUNT_WIDTH) - 64'd1);

   localparam logic [1:0] STATUS_EMIT    = 2'd0;
   localparam logic [1:0] STATUS_REJECT  = 2'd1;
   localparam logic [1:0] STATUS_RESTART = 2'd2;

   localparam logic [2:0] TNF_EMPTY     = 3'd0;
   localparam logic [2:0] TNF_WELL_KNOWN = 3'd1;
   localparam logic [2:0] TNF_EXTERNAL  = 3'd4;
   localparam logic [2:0] TNF_UNKNOWN   = 3'd5;
   localparam logic [2:0] TNF_UNCHANGED = 3'd6;

   localparam logic [7:0] HDR_MB = 8'h80;
   localparam logic [7:0] HDR_ME = 8'h40;
   localparam logic [7:0] HDR_CF = 8'h20;
   localparam logic [7:0] HDR_SR = 8'h10;
   localparam logic [7:0] HDR_IL = 8'h08;

   localparam logic [7:0] SHORT_MAX = 8'hFF;

   typedef struct packed {
      logic [1:0]                     status;
      logic [MAX_BYTES-1:0][7:0]      bytes;
      logic [IDX_WIDTH-1:0]           last_idx;
      logic                           message_complete;
      logic [USED_WIDTH-1:0]          bytes_used;
   } job_type;

endpackage

### hw/rtl/nrhf_front.sv
// Front end: accepts record descriptors, checks them and keeps message state.
// Produces one job per transaction for the queue. Depends on nrhf_pkg.
module nrhf_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [15:0]            csr_buffer_size,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic                   req_cmd,
   input  logic [2:0]             req_tnf,
   input  logic [7:0]             req_type_len,
   input  logic [7:0]             req_id_len,
   input  logic [31:0]            req_payload_len,
   input  logic                   req_chunk,
   input  logic                   req_msg_end,
   output logic                   push_valid,
   input  logic                   push_ready,
   output nrhf_pkg::job_type      push_data
);

   logic [15:0]                         buffer_size_ff, buffer_size_in;
   logic [nrhf_pkg::COUNT_WIDTH-1:0]    position_ff, position_in;
   logic                                started_ff, started_in;
   logic                                ended_ff, ended_in;
   logic                                in_chunk_ff, in_chunk_in;

   logic                                accept;
   logic                                is_short;
   logic                                has_id;
   logic [nrhf_pkg::SMALL_WIDTH-1:0]    small_size;
   logic [nrhf_pkg::SUM_WIDTH-1:0]      sum;
   logic [nrhf_pkg::SUM_WIDTH-1:0]      cap;
   logic                                allowed;
   logic                                fits;
   logic                                take;
   logic [7:0]                          hdr;
   logic [nrhf_pkg::COUNT_WIDTH-1:0]    new_position;

   assign csr_ready  = 1'b1;
   assign req_ready  = push_ready;
   assign push_valid = req_valid;
   assign accept     = req_valid && req_ready;

   assign is_short   = req_payload_len <= 32'(nrhf_pkg::SHORT_MAX);
   assign has_id     = req_id_len != 8'd0;
   assign small_size = nrhf_pkg::SMALL_WIDTH'(is_short ? 3 : 6)
                     + nrhf_pkg::SMALL_WIDTH'(has_id)
                     + nrhf_pkg::SMALL_WIDTH'(req_type_len)
                     + nrhf_pkg::SMALL_WIDTH'(req_id_len);
   assign sum        = nrhf_pkg::SUM_WIDTH'(position_ff)
                     + nrhf_pkg::SUM_WIDTH'(small_size)
                     + nrhf_pkg::SUM_WIDTH'(req_payload_len);
   assign cap        = (nrhf_pkg::SUM_WIDTH'(buffer_size_ff) < nrhf_pkg::COUNT_MAX)
                     ? nrhf_pkg::SUM_WIDTH'(buffer_size_ff) : nrhf_pkg::COUNT_MAX;
   assign fits       = sum <= cap;
   assign new_position = sum[nrhf_pkg::COUNT_WIDTH-1:0];

   always_comb begin
      allowed = 1'b1;
      if (ended_ff) allowed = 1'b0;
      if (in_chunk_ff && has_id) allowed = 1'b0;
      if (in_chunk_ff && req_tnf != nrhf_pkg::TNF_UNCHANGED) allowed = 1'b0;
      if (!in_chunk_ff && req_chunk && req_tnf == nrhf_pkg::TNF_UNCHANGED) allowed = 1'b0;
      if (req_tnf == nrhf_pkg::TNF_EMPTY &&
          (req_type_len != 8'd0 || has_id || req_payload_len != 32'd0)) allowed = 1'b0;
      if (req_tnf >= nrhf_pkg::TNF_WELL_KNOWN && req_tnf <= nrhf_pkg::TNF_EXTERNAL &&
          req_type_len == 8'd0) allowed = 1'b0;
      if (req_tnf == nrhf_pkg::TNF_UNKNOWN && req_type_len != 8'd0) allowed = 1'b0;
   end

   assign take = !req_cmd && allowed && fits;

   always_comb begin
      hdr = 8'(req_tnf);
      if (!started_ff)     hdr = hdr | nrhf_pkg::HDR_MB;
      if (req_msg_end)     hdr = hdr | nrhf_pkg::HDR_ME;
      if (req_chunk)       hdr = hdr | nrhf_pkg::HDR_CF;
      if (is_short)        hdr = hdr | nrhf_pkg::HDR_SR;
      if (has_id)          hdr = hdr | nrhf_pkg::HDR_IL;
   end

   always_comb begin
      push_data = '0;
      if (req_cmd) begin
         push_data.status = nrhf_pkg::STATUS_RESTART;
      end else if (!take) begin
         push_data.status           = nrhf_pkg::STATUS_REJECT;
         push_data.message_complete = ended_ff;
         push_data.bytes_used       = nrhf_pkg::USED_WIDTH'(position_ff);
      end else begin
         push_data.status           = nrhf_pkg::STATUS_EMIT;
         push_data.message_complete = ended_ff || req_msg_end;
         push_data.bytes_used       = nrhf_pkg::USED_WIDTH'(new_position);
         push_data.bytes[0]         = hdr;
         push_data.bytes[1]         = req_type_len;
         if (is_short) begin
            push_data.bytes[2] = req_payload_len[7:0];
            push_data.bytes[3] = req_id_len;
            push_data.last_idx = nrhf_pkg::IDX_WIDTH'(has_id ? 3 : 2);
         end else begin
            push_data.bytes[2] = req_payload_len[31:24];
            push_data.bytes[3] = req_payload_len[23:16];
            push_data.bytes[4] = req_payload_len[15:8];
            push_data.bytes[5] = req_payload_len[7:0];
            push_data.bytes[6] = req_id_len;
            push_data.last_idx = nrhf_pkg::IDX_WIDTH'(has_id ? 6 : 5);
         end
      end
   end

   always_comb begin
      buffer_size_in = csr_valid ? csr_buffer_size : buffer_size_ff;
      position_in    = position_ff;
      started_in     = started_ff;
      ended_in       = ended_ff;
      in_chunk_in    = in_chunk_ff;
      if (accept && req_cmd) begin
         position_in = '0;
         started_in  = 1'b0;
         ended_in    = 1'b0;
         in_chunk_in = 1'b0;
      end else if (accept && take) begin
         position_in = new_position;
         started_in  = 1'b1;
         if (req_msg_end) ended_in = 1'b1;
         if (req_chunk) in_chunk_in = 1'b1;
         else if (req_tnf == nrhf_pkg::TNF_UNCHANGED) in_chunk_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buffer_size_ff <= 16'hFFFF;
         position_ff    <= '0;
         started_ff     <= 1'b0;
         ended_ff       <= 1'b0;
         in_chunk_ff    <= 1'b0;
      end else begin
         buffer_size_ff <= buffer_size_in;
         position_ff    <= position_in;
         started_ff     <= started_in;
         ended_ff       <= ended_in;
         in_chunk_ff    <= in_chunk_in;
      end
   end

   a_ended_needs_start: assert property (@(posedge clock) disable iff (reset)
      ended_ff |-> started_ff) else $error("message ended without a start");
   a_chunk_needs_start: assert property (@(posedge clock) disable iff (reset)
      in_chunk_ff |-> started_ff) else $error("chunk open without a start");
   a_restart_clears: assert property (@(posedge clock) disable iff (reset)
      accept && req_cmd |=> position_ff == '0 && !started_ff)
      else $error("restart did not clear state");

endmodule

### hw/rtl/nrhf_queue.sv
// Short job queue between the checker front and the byte emitter.
// Depends on nrhf_pkg for the job type and depth.
module nrhf_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push_valid,
   output logic                   push_ready,
   input  nrhf_pkg::job_type      push_data,
   output logic                   pop_valid,
   input  logic                   pop_ready,
   output nrhf_pkg::job_type      pop_data
);

   nrhf_pkg::job_type                  q_ff [nrhf_pkg::QUEUE_DEPTH];
   logic [nrhf_pkg::PTR_WIDTH-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [nrhf_pkg::PTR_WIDTH-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [nrhf_pkg::FILL_WIDTH-1:0]    fill_ff, fill_in;
   logic                               push;
   logic                               pop;

   assign push_ready = fill_ff != nrhf_pkg::FILL_WIDTH'(nrhf_pkg::QUEUE_DEPTH);
   assign pop_valid  = fill_ff != '0;
   assign pop_data   = q_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == nrhf_pkg::PTR_WIDTH'(nrhf_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_ff + nrhf_pkg::PTR_WIDTH'(1);
      if (pop)  rd_ptr_in = (rd_ptr_ff == nrhf_pkg::PTR_WIDTH'(nrhf_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_ff + nrhf_pkg::PTR_WIDTH'(1);
      if (push && !pop) fill_in = fill_ff + nrhf_pkg::FILL_WIDTH'(1);
      if (pop && !push) fill_in = fill_ff - nrhf_pkg::FILL_WIDTH'(1);
   end

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= push_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= nrhf_pkg::FILL_WIDTH'(nrhf_pkg::QUEUE_DEPTH))
      else $error("queue overfilled");
   a_ptr_match: assert property (@(posedge clock) disable iff (reset)
      fill_ff == '0 || fill_ff == nrhf_pkg::FILL_WIDTH'(nrhf_pkg::QUEUE_DEPTH)
      |-> wr_ptr_ff == rd_ptr_ff) else $error("queue pointers out of step");
   a_head_known: assert property (@(posedge clock) disable iff (reset)
      pop_valid |-> !$isunknown(pop_data.status)) else $error("queue head unknown");

endmodule

### hw/rtl/nrhf_back.sv
// Back end: walks each queued job into the result register, one header byte per
// cycle unless rsp_ready stalls it. Depends on nrhf_pkg for the job type.
module nrhf_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pop_valid,
   output logic                   pop_ready,
   input  nrhf_pkg::job_type      pop_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [1:0]             rsp_status,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_last,
   output logic                   rsp_message_complete,
   output logic [15:0]            rsp_bytes_used
);

   logic [nrhf_pkg::IDX_WIDTH-1:0]   idx_ff, idx_in;
   logic                             valid_ff, valid_in;
   logic [1:0]                       status_ff;
   logic [7:0]                       byte_ff;
   logic                             last_ff;
   logic                             complete_ff;
   logic [15:0]                      used_ff;
   logic                             out_free;
   logic                             emit;
   logic                             is_last;

   assign out_free  = !valid_ff || rsp_ready;
   assign emit      = pop_valid && out_free;
   assign is_last   = idx_ff == pop_data.last_idx;
   assign pop_ready = emit && is_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (out_free) valid_in = emit;
      if (emit) idx_in = is_last ? '0 : idx_ff + nrhf_pkg::IDX_WIDTH'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         status_ff   <= pop_data.status;
         byte_ff     <= pop_data.bytes[idx_ff];
         last_ff     <= is_last;
         complete_ff <= pop_data.message_complete;
         used_ff     <= 16'(pop_data.bytes_used);
      end
   end

   assign rsp_valid            = valid_ff;
   assign rsp_status           = status_ff;
   assign rsp_out_byte         = byte_ff;
   assign rsp_last             = last_ff;
   assign rsp_message_complete = complete_ff;
   assign rsp_bytes_used       = used_ff;

   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      pop_valid |-> idx_ff <= pop_data.last_idx) else $error("byte index past job end");
   a_single_result: assert property (@(posedge clock) disable iff (reset)
      valid_ff && status_ff != nrhf_pkg::STATUS_EMIT |-> last_ff)
      else $error("reject or restart result not marked last");
   a_idle_index: assert property (@(posedge clock) disable iff (reset)
      !pop_valid |-> idx_ff == '0) else $error("index left mid-job");

endmodule

### hw/rtl/ndef_record_header_framer.sv
// NDEF record header framer, top level.
// Request channel (req_*): one record descriptor or a restart command per transaction.
// Result channel (rsp_*): header bytes, a reject result or a restart result.
// Config channel (csr_*): buffer_size, always ready; write only while idle.
// An accepted record yields 3 to 7 results, one header byte each, in order:
// flags/TNF, type length, payload length (1 or 4 bytes big-endian), ID length if IL set.
// A rejected record or a restart yields one result; rsp_last marks the final one.
// With the emitter idle, a request is written into the job queue, and its first
// result is then registered in the result register. The byte emitter sends one
// result per cycle unless rsp_ready stalls it: one per header byte of a record,
// one for a reject or restart. The front runs ahead through a 2-entry job queue
// and checks one request per cycle while the queue has room. A stalled rsp_ready
// holds the result register; the queue then fills and req_ready drops. Reset
// clears position, message flags and queue, and sets buffer_size 65535.
// Depends on nrhf_pkg, nrhf_front, nrhf_queue and nrhf_back.
module ndef_record_header_framer (
   input  logic           clock,
   input  logic           reset,
   input  logic           csr_valid,
   output logic           csr_ready,
   input  logic [15:0]    csr_buffer_size,
   input  logic           req_valid,
   output logic           req_ready,
   input  logic           req_cmd,
   input  logic [2:0]     req_tnf,
   input  logic [7:0]     req_type_len,
   input  logic [7:0]     req_id_len,
   input  logic [31:0]    req_payload_len,
   input  logic           req_chunk,
   input  logic           req_msg_end,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output logic [1:0]     rsp_status,
   output logic [7:0]     rsp_out_byte,
   output logic           rsp_last,
   output logic           rsp_message_complete,
   output logic [15:0]    rsp_bytes_used
);

   logic                 push_valid;
   logic                 push_ready;
   nrhf_pkg::job_type    push_data;
   logic                 pop_valid;
   logic                 pop_ready;
   nrhf_pkg::job_type    pop_data;

   nrhf_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_buffer_size (csr_buffer_size),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_cmd         (req_cmd),
      .req_tnf         (req_tnf),
      .req_type_len    (req_type_len),
      .req_id_len      (req_id_len),
      .req_payload_len (req_payload_len),
      .req_chunk       (req_chunk),
      .req_msg_end     (req_msg_end),
      .push_valid      (push_valid),
      .push_ready      (push_ready),
      .push_data       (push_data)
   );

   nrhf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   nrhf_back u_back (
      .clock                (clock),
      .reset                (reset),
      .pop_valid            (pop_valid),
      .pop_ready            (pop_ready),
      .pop_data             (pop_data),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_status           (rsp_status),
      .rsp_out_byte         (rsp_out_byte),
      .rsp_last             (rsp_last),
      .rsp_message_complete (rsp_message_complete),
      .rsp_bytes_used       (rsp_bytes_used)
   );

endmodule
